// ===== rtl/tss_pkg.sv =====
package tss_pkg;

	// Configuration register map
	localparam int CFG_IDX_BITS = 1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CANVAS_WIDTH  = 1'b0,
		REG_CANVAS_HEIGHT = 1'b1
	} cfg_reg_t;

	// Canvas size after reset, both axes
	localparam int CANVAS_RESET = 240;

endpackage

// ===== rtl/tss_div.sv =====
module tss_div #(
	parameter int W = 12
) (
	input  logic           clk,
	input  logic [2*W-1:0] num,
	input  logic [W-1:0]   den,
	output logic [W-1:0]   quot
);

	// Restoring division, one quotient bit per stage, MSB first.
	// Requires num < den * 2^W.
	logic [2*W-1:0] rem_s [W-1];
	logic [W-1:0]   den_s [W-1];
	logic [W-1:0]   quo_s [W];

	for (genvar k = 0; k < W; k++) begin : g_step
		localparam int BIT = W - 1 - k;
		logic [2*W-1:0] rem_in;
		logic [2*W-1:0] sub;
		logic [W-1:0]   den_in;
		logic [W-1:0]   quo_in;
		logic           fit;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign sub = (2*W)'(den_in) << BIT;
		assign fit = (rem_in >= sub);

		always_ff @(posedge clk) begin
			quo_s[k] <= fit ? (quo_in | (W'(1) << BIT)) : quo_in;
		end

		if (k < W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= fit ? (rem_in - sub) : rem_in;
				den_s[k] <= den_in;
			end
		end
	end

	assign quot = quo_s[W-1];

endmodule

// ===== rtl/triangle_scanline_span.sv =====
// Each item passes the sort, edge, multiply, divider, sign and clip register stages;
// done comes from a register and is high while each result is on the ports.
// Throughput: one transaction per cycle; busy is always low and results flow without stall.
// Most of the pipeline lies in the two restoring dividers, one quotient bit per stage.
// Reset (arst_n low, asynchronous) empties the pipeline and sets both canvas sizes to 240.
// The receiver cannot stall: each result is on the ports for exactly one cycle with done.
module triangle_scanline_span
	import tss_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int CANVAS_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Item channel
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        ax,
	input  logic signed [COORD_BITS-1:0]        ay,
	input  logic signed [COORD_BITS-1:0]        bx,
	input  logic signed [COORD_BITS-1:0]        by_coord,
	input  logic signed [COORD_BITS-1:0]        cx_coord,
	input  logic signed [COORD_BITS-1:0]        cy_coord,
	input  logic signed [COORD_BITS-1:0]        row,
	// Configuration write port
	input  logic                                cfg_we,
	input  logic [CFG_IDX_BITS-1:0]             cfg_index,
	input  logic [CANVAS_BITS:0]                cfg_data,
	// Result channel
	output logic                                done,
	output logic                                visible,
	output logic [CANVAS_BITS-1:0]              span_start,
	output logic [CANVAS_BITS-1:0]              span_end
);

	localparam int C  = COORD_BITS;
	localparam int CB = CANVAS_BITS;
	// Signed working width for the final x positions and the clip compares
	localparam int XW = ((C > CB + 1) ? C : CB + 1) + 2;
	localparam logic [CB:0] CANVAS_MAX = {1'b1, {CB{1'b0}}};

	// Data carried alongside the dividers
	typedef struct packed {
		logic signed [C-1:0] x_long;   // start x of the long edge
		logic signed [C-1:0] x_short;  // start x of the short edge
		logic signed [C-1:0] x_end;    // bottom vertex x, used on a flat lower edge
		logic                neg_long;
		logic                neg_short;
		logic                flat_low;
		logic                kill;     // row produces no span at all
	} side_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [CB:0] width_q;
	logic [CB:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= (CB+1)'(CANVAS_RESET);
			height_q <= (CB+1)'(CANVAS_RESET);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CANVAS_WIDTH:  width_q  <= cfg_data;
				REG_CANVAS_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	// Clamp oversized registers to the canvas maximum
	logic [CB:0] width_c;
	logic [CB:0] height_c;
	assign width_c  = (width_q  > CANVAS_MAX) ? CANVAS_MAX : width_q;
	assign height_c = (height_q > CANVAS_MAX) ? CANVAS_MAX : height_q;

	// The pipeline never holds off a new transaction
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// ------------------------------------------------------------------
	// Stage 1: sort vertices by y with strict compare-swaps 0-1, 0-2, 1-2
	// ------------------------------------------------------------------
	logic signed [C-1:0] p0x, p0y, p1x, p1y, p2x, p2y, tx, ty;

	always_comb begin
		tx  = '0;       ty  = '0;
		p0x = ax;       p0y = ay;
		p1x = bx;       p1y = by_coord;
		p2x = cx_coord; p2y = cy_coord;
		if (p0y > p1y) begin
			tx = p0x; ty = p0y; p0x = p1x; p0y = p1y; p1x = tx; p1y = ty;
		end
		if (p0y > p2y) begin
			tx = p0x; ty = p0y; p0x = p2x; p0y = p2y; p2x = tx; p2y = ty;
		end
		if (p1y > p2y) begin
			tx = p1x; ty = p1y; p1x = p2x; p1y = p2y; p2x = tx; p2y = ty;
		end
	end

	logic                valid_s1;
	logic signed [C-1:0] x0_s1, y0_s1, x1_s1, y1_s1, x2_s1, y2_s1, row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		x0_s1  <= p0x; y0_s1 <= p0y;
		x1_s1  <= p1x; y1_s1 <= p1y;
		x2_s1  <= p2x; y2_s1 <= p2y;
		row_s1 <= row;
	end

	// ------------------------------------------------------------------
	// Stage 2: pick the edges, form deltas, flag rows that show nothing
	// ------------------------------------------------------------------
	logic              upper;
	logic signed [C:0] dxl, dxs, dyl, dys, dnl, dns;
	logic [C:0]        magl, mags;
	logic signed [XW-1:0] row_x, height_x;
	logic              kill_c;

	always_comb begin
		upper = (row_s1 < y1_s1);
		dxl   = (C+1)'(x2_s1) - (C+1)'(x0_s1);
		dyl   = (C+1)'(row_s1) - (C+1)'(y0_s1);
		dnl   = (C+1)'(y2_s1) - (C+1)'(y0_s1);
		if (upper) begin
			dxs = (C+1)'(x1_s1) - (C+1)'(x0_s1);
			dys = (C+1)'(row_s1) - (C+1)'(y0_s1);
			dns = (C+1)'(y1_s1) - (C+1)'(y0_s1);
		end else begin
			dxs = (C+1)'(x2_s1) - (C+1)'(x1_s1);
			dys = (C+1)'(row_s1) - (C+1)'(y1_s1);
			dns = (C+1)'(y2_s1) - (C+1)'(y1_s1);
		end
		// Divide magnitudes, reapply the sign later: truncates toward zero
		magl     = dxl[C] ? -dxl : dxl;
		mags     = dxs[C] ? -dxs : dxs;
		row_x    = XW'(row_s1);
		height_x = XW'({1'b0, height_c});
		kill_c   = (y2_s1 == y0_s1) || (row_s1 < y0_s1) || (row_s1 > y2_s1)
			|| (row_s1 < 0) || (row_x >= height_x);
	end

	logic          valid_s2;
	logic [C-1:0]  magl_s2, mags_s2, dyl_s2, dys_s2, dnl_s2, dns_s2;
	side_t         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		magl_s2 <= magl[C-1:0];
		mags_s2 <= mags[C-1:0];
		dyl_s2  <= dyl[C-1:0];
		dys_s2  <= dys[C-1:0];
		dnl_s2  <= dnl[C-1:0];
		dns_s2  <= dns[C-1:0];
		side_s2.x_long    <= x0_s1;
		side_s2.x_short   <= upper ? x0_s1 : x1_s1;
		side_s2.x_end     <= x2_s1;
		side_s2.neg_long  <= dxl[C];
		side_s2.neg_short <= dxs[C];
		side_s2.flat_low  <= ~upper && (y2_s1 == y1_s1);
		side_s2.kill      <= kill_c;
	end

	// ------------------------------------------------------------------
	// Stage 3: |dx| * dy for both edges
	// ------------------------------------------------------------------
	logic            valid_s3;
	logic [2*C-1:0]  numl_s3, nums_s3;
	logic [C-1:0]    dnl_s3, dns_s3;
	side_t           side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		numl_s3 <= (2*C)'(magl_s2) * (2*C)'(dyl_s2);
		nums_s3 <= (2*C)'(mags_s2) * (2*C)'(dys_s2);
		dnl_s3  <= dnl_s2;
		dns_s3  <= dns_s2;
		side_s3 <= side_s2;
	end

	// ------------------------------------------------------------------
	// Division stages: two lanes, side data delayed to match
	// ------------------------------------------------------------------
	logic [C-1:0] ql, qs;

	tss_div #(.W(C)) u_div_long (
		.clk  (clk),
		.num  (numl_s3),
		.den  (dnl_s3),
		.quot (ql)
	);

	tss_div #(.W(C)) u_div_short (
		.clk  (clk),
		.num  (nums_s3),
		.den  (dns_s3),
		.quot (qs)
	);

	logic  valid_d [C];
	side_t side_d  [C];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < C; k++) begin
				valid_d[k] <= 1'b0;
			end
		end else begin
			valid_d[0] <= valid_s3;
			for (int k = 1; k < C; k++) begin
				valid_d[k] <= valid_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_d[0] <= side_s3;
		for (int k = 1; k < C; k++) begin
			side_d[k] <= side_d[k-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: reapply signs, add the edge start points
	// ------------------------------------------------------------------
	side_t             side_e;
	logic signed [XW-1:0] qlx, qsx, xa, xb;

	assign side_e = side_d[C-1];

	always_comb begin
		qlx = XW'({1'b0, ql});
		qsx = XW'({1'b0, qs});
		xa  = XW'(side_e.x_long) + (side_e.neg_long ? -qlx : qlx);
		if (side_e.flat_low) begin
			xb = XW'(side_e.x_end);
		end else begin
			xb = XW'(side_e.x_short) + (side_e.neg_short ? -qsx : qsx);
		end
	end

	logic                 valid_s4, kill_s4;
	logic signed [XW-1:0] xa_s4, xb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_d[C-1];
		end
	end

	always_ff @(posedge clk) begin
		xa_s4   <= xa;
		xb_s4   <= xb;
		kill_s4 <= side_e.kill;
	end

	// ------------------------------------------------------------------
	// Stage 5: order the ends, clip to the canvas, drive the result
	// ------------------------------------------------------------------
	logic signed [XW-1:0] lo, hi, sx, ex, wm1;
	logic                 vis;

	always_comb begin
		lo  = (xa_s4 < xb_s4) ? xa_s4 : xb_s4;
		hi  = (xa_s4 < xb_s4) ? xb_s4 : xa_s4;
		wm1 = XW'({1'b0, width_c}) - XW'(1);
		sx  = (lo < 0) ? '0 : lo;
		ex  = (hi > wm1) ? wm1 : hi;
		vis = ~kill_s4 && (sx <= ex);
	end

	logic          done_s5, visible_s5;
	logic [CB-1:0] start_s5, end_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5    <= 1'b0;
			visible_s5 <= 1'b0;
			start_s5   <= '0;
			end_s5     <= '0;
		end else begin
			done_s5    <= valid_s4;
			// Drop the span to zero whenever the row is killed or its clipped span is empty
			visible_s5 <= valid_s4 & vis;
			start_s5   <= vis ? sx[CB-1:0] : '0;
			end_s5     <= vis ? ex[CB-1:0] : '0;
		end
	end

	assign done       = done_s5;
	assign visible    = visible_s5;
	assign span_start = start_s5;
	assign span_end   = end_s5;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Register stages from the input ports to done
	localparam int LAT = C + 5;

	// Every result strobe traces back to an accepted transaction
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result strobe without a matching transaction");

	// A visible span is ordered
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		visible |-> (span_start <= span_end))
		else $error("span start beyond span end");

	// A visible span stays inside the canvas width
	a_span_clip: assert property (@(posedge clk) disable iff (!arst_n)
		visible |-> ({1'b0, span_end} < width_c))
		else $error("span end beyond the last column");

	// A killed row leaves the divider stages and comes out invisible
	a_kill_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_d[C-1] && side_e.kill) |=> ##1 (done && !visible))
		else $error("killed row reported as visible");

	// Visible only together with the strobe
	a_vis_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		visible |-> done)
		else $error("visible flag without result strobe");

endmodule
